[rtl/ffea_pkg.sv]
package ffea_pkg;

   localparam int unsigned SectorShift = 9;
   localparam int unsigned SectorBits  = 24;
   localparam int unsigned RegBits     = 28;

   localparam logic [0:0] OpWrite = 1'b0;
   localparam logic [0:0] OpQuery = 1'b1;

   localparam logic [0:0] CsrTotalSectors    = 1'b0;
   localparam logic [0:0] CsrFirstDataSector = 1'b1;

   typedef struct packed {
      logic        op;
      logic [8:0]  entry_index;
      logic        entry_valid;
      logic [31:0] entry_start;
      logic [31:0] entry_bytes;
      logic [31:0] request_bytes;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] alloc_sector;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // latch request, reset cursor and last key
      logic write;      // perform table write
      logic scan_begin; // start a scan pass
      logic scan_step;  // read next slot (address advances)
      logic take;       // commit pass minimum as next extent
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clearing;   // table clear after reset still running
      logic scan_last;  // final slot address issued this cycle
      logic scan_done;  // last read data processed
      logic have_min;   // pass found an extent
      logic fits;       // gap to chosen extent holds need
      logic tail_fits;  // trailing gap holds need
   } sts_type;

   function automatic logic [SectorBits-1:0] bytes_to_sectors(input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, b} + 33'd511;
      return s[SectorShift+SectorBits-1:SectorShift];
   endfunction

endpackage

[rtl/ffea_ctrl.sv]
module ffea_ctrl
   import ffea_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    is_query,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy,
   output logic    rsp_valid,
   output logic    rsp_found
);

   typedef enum logic [2:0] {
      CLEAR, IDLE, WRITE, PASS_BEGIN, SCAN, DRAIN, DECIDE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_found_ff, rsp_found_in;

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         CLEAR: begin
            if (!sts.clearing) begin
               busy_in  = 1'b0;
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               busy_in  = 1'b1;
               state_in = is_query ? PASS_BEGIN : WRITE;
            end
         end
         WRITE: begin
            cmd.write    = 1'b1;
            rsp_valid_in = 1'b1;
            busy_in      = 1'b0;
            state_in     = IDLE;
         end
         PASS_BEGIN: begin
            cmd.scan_begin = 1'b1;
            state_in       = SCAN;
         end
         SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = DRAIN;
         end
         DRAIN: begin
            if (sts.scan_done) state_in = DECIDE;
         end
         DECIDE: begin
            if (sts.have_min) begin
               if (sts.fits) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b1;
                  busy_in      = 1'b0;
                  state_in     = IDLE;
               end else begin
                  cmd.take = 1'b1;
                  state_in = PASS_BEGIN;
               end
            end else begin
               rsp_valid_in = 1'b1;
               rsp_found_in = sts.tail_fits;
               busy_in      = 1'b0;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         rsp_found_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_found_ff <= rsp_found_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

endmodule

[rtl/ffea_datapath.sv]
module ffea_datapath
   import ffea_pkg::*;
#(
   parameter int unsigned TABLE_SLOTS = 512,
   parameter int unsigned IDX_BITS    = 9
) (
   input  logic               clock,
   input  logic               reset,
   input  req_type            req,
   input  cmd_type            cmd,
   input  logic [RegBits-1:0] total_sectors,
   input  logic [RegBits-1:0] first_data_sector,
   output sts_type            sts,
   output logic [31:0]        cursor
);

   // Walk order: repeated passes each pick the smallest (start, slot) key
   // strictly above the previous pick.
   logic                    mem_valid [TABLE_SLOTS];
   logic [31:0]             mem_start [TABLE_SLOTS];
   logic [SectorBits-1:0]   mem_sec   [TABLE_SLOTS];

   logic                    clearing_ff;
   logic [IDX_BITS:0]       clr_addr_ff;

   req_type                 req_ff;
   logic [SectorBits-1:0]   need_ff;
   logic [31:0]             cursor_ff;
   logic                    have_last_ff;
   logic [31:0]             last_start_ff;
   logic [IDX_BITS-1:0]     last_idx_ff;

   logic [IDX_BITS:0]       addr_ff;
   logic                    rd_vld_ff;
   logic [IDX_BITS-1:0]     rd_idx_ff;
   logic                    rd_valid_ff;
   logic [31:0]             rd_start_ff;
   logic [SectorBits-1:0]   rd_sec_ff;

   logic                    have_min_ff;
   logic [31:0]             min_start_ff;
   logic [IDX_BITS-1:0]     min_idx_ff;
   logic [SectorBits-1:0]   min_sec_ff;

   logic                    above, below;
   logic [31:0]             gap, tail;
   logic [IDX_BITS-1:0]     widx;
   logic                    wr_ok;

   assign widx  = IDX_BITS'(req_ff.entry_index);
   assign wr_ok = cmd.write && ({23'd0, req_ff.entry_index} < 32'(TABLE_SLOTS));

   // after reset, valid marks are cleared one slot per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == (IDX_BITS+1)'(TABLE_SLOTS - 1)) clearing_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem_valid[clr_addr_ff[IDX_BITS-1:0]] <= 1'b0;
      end else if (wr_ok) begin
         mem_valid[widx] <= req_ff.entry_valid;
      end
      if (wr_ok) begin
         mem_start[widx] <= req_ff.entry_start;
         mem_sec[widx]   <= bytes_to_sectors(req_ff.entry_bytes);
      end
      rd_start_ff <= mem_start[addr_ff[IDX_BITS-1:0]];
      rd_sec_ff   <= mem_sec[addr_ff[IDX_BITS-1:0]];
      rd_valid_ff <= mem_valid[addr_ff[IDX_BITS-1:0]];
      rd_idx_ff   <= addr_ff[IDX_BITS-1:0];
   end

   // candidate key strictly above last pick, and below current minimum
   assign above = !have_last_ff || (rd_start_ff > last_start_ff) ||
                  ((rd_start_ff == last_start_ff) && (rd_idx_ff > last_idx_ff));
   assign below = !have_min_ff || (rd_start_ff < min_start_ff) ||
                  ((rd_start_ff == min_start_ff) && (rd_idx_ff < min_idx_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         addr_ff     <= '0;
         have_min_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_step;
         if (cmd.scan_begin) begin
            addr_ff     <= '0;
            have_min_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            addr_ff <= addr_ff + 1'b1;
         end
         if (rd_vld_ff && rd_valid_ff && above && below) begin
            have_min_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff && rd_valid_ff && above && below) begin
         min_start_ff <= rd_start_ff;
         min_idx_ff   <= rd_idx_ff;
         min_sec_ff   <= rd_sec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff    <= req;
         need_ff   <= bytes_to_sectors(req.request_bytes);
         cursor_ff <= {4'd0, first_data_sector};
      end else if (cmd.take) begin
         cursor_ff     <= min_start_ff + {8'd0, min_sec_ff};
         last_start_ff <= min_start_ff;
         last_idx_ff   <= min_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_last_ff <= 1'b0;
      end else if (cmd.load) begin
         have_last_ff <= 1'b0;
      end else if (cmd.take) begin
         have_last_ff <= 1'b1;
      end
   end

   assign gap  = min_start_ff - cursor_ff;
   assign tail = {4'd0, total_sectors} - 32'd1 - cursor_ff;

   assign sts.clearing  = clearing_ff;
   assign sts.scan_last = cmd.scan_step && (addr_ff == (IDX_BITS+1)'(TABLE_SLOTS - 1));
   assign sts.scan_done = !rd_vld_ff;
   assign sts.have_min  = have_min_ff;
   assign sts.fits      = gap >= {8'd0, need_ff};
   assign sts.tail_fits = tail >= {8'd0, need_ff};
   assign cursor        = cursor_ff;

endmodule

[rtl/first_fit_extent_allocator.sv]
// First-fit extent allocator.
// Input channel: present a req_ item with start high; it is taken at a rising
// edge where start is high and busy is low. op = write stores one table slot
// (valid, start sector, byte size rounded up to 512-byte sectors); op = query
// looks for the first gap, from first_data_sector, walking valid extents in
// ascending start order (ties in slot order), then the trailing gap below
// total_sectors - 1.
// Result channel: one rsp_ transfer per item, marked by rsp_valid for one
// cycle; the receiver cannot stall it, so it must sample on that cycle.
// A query runs one pass over the slot memory per extent stepped over, plus
// a final pass; the single read port of the slot memory sets this cost.
// Configuration: csr_ writes are always accepted (csr_ready high); index 0 is
// total_sectors, index 1 first_data_sector; other indices are dropped.
// Reset (synchronous): registers return to 65535 and 21, then the table is
// cleared one slot per cycle; busy stays high until the clear has finished.
module first_fit_extent_allocator
   import ffea_pkg::*;
#(
   parameter int unsigned TABLE_SLOTS = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int unsigned IdxBits = $clog2(TABLE_SLOTS);

   logic [RegBits-1:0] total_ff;
   logic [RegBits-1:0] first_ff;
   cmd_type            cmd;
   sts_type            sts;
   logic [31:0]        cursor;
   logic               found;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= RegBits'(65535);
         first_ff <= RegBits'(21);
      end else if (csr_valid) begin
         case (csr_index)
            CsrTotalSectors:    total_ff <= csr_data[RegBits-1:0];
            CsrFirstDataSector: first_ff <= csr_data[RegBits-1:0];
            default: ;
         endcase
      end
   end

   ffea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .is_query  (req_item.op == OpQuery),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_found (found)
   );

   ffea_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .IDX_BITS    (IdxBits)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req               (req_item),
      .cmd               (cmd),
      .total_sectors     (total_ff),
      .first_data_sector (first_ff),
      .sts               (sts),
      .cursor            (cursor)
   );

   // cursor holds still until the next item is loaded
   assign rsp_item.found        = found;
   assign rsp_item.alloc_sector = found ? cursor : 32'd0;

endmodule
